// ===== src/tsag_pkg.sv =====
// tsag_pkg: shared types and constants for the texture swizzle address generator
// no dependencies; used by the interfaces, tsag_walker and the top level module
`timescale 1ns / 1ps
`default_nettype none

package tsag_pkg;

  // offset table entry width; the swizzled address adds the element shift of up to 3
  localparam int unsigned OFFSET_BITS = 32;

  // fixed field widths of the channels
  localparam int unsigned CMD_W      = 3;
  localparam int unsigned TIDX_W     = 12;
  localparam int unsigned TVAL_W     = 32;
  localparam int unsigned LINEAR_W   = 36;
  localparam int unsigned SWZ_ADDR_W = OFFSET_BITS + 3;
  localparam int unsigned CNT_W      = 13;
  localparam int unsigned REG_IDX_W  = 3;
  localparam int unsigned BYTE_W     = 3;
  localparam int unsigned ESL_W      = 2;

  // command codes of an input transaction
  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_C  = 3'd0,
    CMD_LOAD_X  = 3'd1,
    CMD_LOAD_Y  = 3'd2,
    CMD_LOAD_Z  = 3'd3,
    CMD_ADVANCE = 3'd4
  } cmd_e;

  // configuration register indexes
  typedef enum logic [REG_IDX_W-1:0] {
    REG_CHANNEL_COUNT = 3'd0,
    REG_X_COUNT       = 3'd1,
    REG_Y_COUNT       = 3'd2,
    REG_Z_COUNT       = 3'd3,
    REG_ELEM_LOG2     = 3'd4,
    REG_DIRECTION     = 3'd5
  } reg_e;

  // per-byte walk information handed from the walker to the address pipeline
  typedef struct packed {
    logic [LINEAR_W-1:0] linear;
    logic [BYTE_W-1:0]   pos_byte;
    logic [ESL_W-1:0]    esl;
    logic                dir;
    logic                last;
  } step_t;

endpackage

`default_nettype wire

// ===== src/tsag_if.sv =====
// tsag_if: valid/ready channel interfaces for input, result and configuration
// depends on tsag_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface tsag_in_if;
  logic                          valid;
  logic                          ready;
  logic [tsag_pkg::CMD_W-1:0]    cmd;
  logic [tsag_pkg::TIDX_W-1:0]   table_index;
  logic [tsag_pkg::TVAL_W-1:0]   table_value;

  modport source (output valid, cmd, table_index, table_value, input ready);
  modport sink   (input valid, cmd, table_index, table_value, output ready);
endinterface

interface tsag_out_if;
  logic                              valid;
  logic                              ready;
  logic [tsag_pkg::LINEAR_W-1:0]     linear_address;
  logic [tsag_pkg::SWZ_ADDR_W-1:0]   swizzled_address;
  logic                              source_is_linear;
  logic                              last;

  modport source (output valid, linear_address, swizzled_address, source_is_linear, last,
                  input ready);
  modport sink   (input valid, linear_address, swizzled_address, source_is_linear, last,
                  output ready);
endinterface

interface tsag_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [tsag_pkg::REG_IDX_W-1:0]    reg_index;
  logic [tsag_pkg::CNT_W-1:0]        wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

`default_nettype wire

// ===== src/tsag_ram.sv =====
// tsag_ram: generic single write port, single read port RAM with registered read
// no package dependencies
`timescale 1ns / 1ps
`default_nettype none

module tsag_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output      logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, held while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== src/tsag_walker.sv =====
// tsag_walker: configuration registers and the byte/channel/x/y/z walk counters
// depends on tsag_pkg for register codes and the step_t struct
`timescale 1ns / 1ps
`default_nettype none

module tsag_walker #(
  parameter int unsigned TABLE_DEPTH = 4096,
  parameter int unsigned IDX_W       = 12
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [tsag_pkg::REG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [tsag_pkg::CNT_W-1:0]     cfg_data_i,
  input  wire logic                           step_i,
  output      logic [IDX_W-1:0]               pos_c_o,
  output      logic [IDX_W-1:0]               pos_x_o,
  output      logic [IDX_W-1:0]               pos_y_o,
  output      logic [IDX_W-1:0]               pos_z_o,
  output      tsag_pkg::step_t                info_o
);

  localparam int unsigned CMP_W = (IDX_W + 2 > tsag_pkg::CNT_W + 1) ?
                                  IDX_W + 2 : tsag_pkg::CNT_W + 1;

  logic [tsag_pkg::CNT_W-1:0]    cnt_c_q, cnt_x_q, cnt_y_q, cnt_z_q;
  logic [tsag_pkg::ESL_W-1:0]    esl_q;
  logic                          dir_q;
  logic [tsag_pkg::BYTE_W-1:0]   pos_b_q, pos_b_d;
  logic [IDX_W-1:0]              pos_c_q, pos_c_d, pos_x_q, pos_x_d;
  logic [IDX_W-1:0]              pos_y_q, pos_y_d, pos_z_q, pos_z_d;
  logic [tsag_pkg::LINEAR_W-1:0] lin_q, lin_d;
  logic                          restart;
  logic                          end_b, end_c, end_x, end_y, end_z, last;

  // count clamped to 1..TABLE_DEPTH
  function automatic logic [CMP_W-1:0] eff_count(input logic [tsag_pkg::CNT_W-1:0] v);
    logic [CMP_W-1:0] r;
    r = CMP_W'(v);
    if (v == '0) begin
      r = CMP_W'(1);
    end else if (r > CMP_W'(TABLE_DEPTH)) begin
      r = CMP_W'(TABLE_DEPTH);
    end
    return r;
  endfunction

  // register decode; a write inside the list restarts the walk
  always_comb begin
    restart = 1'b0;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tsag_pkg::REG_CHANNEL_COUNT, tsag_pkg::REG_X_COUNT, tsag_pkg::REG_Y_COUNT,
        tsag_pkg::REG_Z_COUNT, tsag_pkg::REG_ELEM_LOG2, tsag_pkg::REG_DIRECTION: begin
          restart = 1'b1;
        end
        default: restart = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_c_q <= tsag_pkg::CNT_W'(1);
      cnt_x_q <= tsag_pkg::CNT_W'(1);
      cnt_y_q <= tsag_pkg::CNT_W'(1);
      cnt_z_q <= tsag_pkg::CNT_W'(1);
      esl_q   <= '0;
      dir_q   <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tsag_pkg::REG_CHANNEL_COUNT: cnt_c_q <= cfg_data_i;
        tsag_pkg::REG_X_COUNT:       cnt_x_q <= cfg_data_i;
        tsag_pkg::REG_Y_COUNT:       cnt_y_q <= cfg_data_i;
        tsag_pkg::REG_Z_COUNT:       cnt_z_q <= cfg_data_i;
        tsag_pkg::REG_ELEM_LOG2:     esl_q   <= cfg_data_i[tsag_pkg::ESL_W-1:0];
        tsag_pkg::REG_DIRECTION:     dir_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // end-of-loop flags for the current position
  always_comb begin
    end_b = ({1'b0, pos_b_q} + 4'd1) >= (4'd1 << esl_q);
    end_c = (CMP_W'(pos_c_q) + CMP_W'(1)) >= eff_count(cnt_c_q);
    end_x = (CMP_W'(pos_x_q) + CMP_W'(1)) >= eff_count(cnt_x_q);
    end_y = (CMP_W'(pos_y_q) + CMP_W'(1)) >= eff_count(cnt_y_q);
    end_z = (CMP_W'(pos_z_q) + CMP_W'(1)) >= eff_count(cnt_z_q);
    last  = end_b && end_c && end_x && end_y && end_z;
  end

  // nested counter advance, byte fastest and z outermost
  always_comb begin
    pos_b_d = pos_b_q;
    pos_c_d = pos_c_q;
    pos_x_d = pos_x_q;
    pos_y_d = pos_y_q;
    pos_z_d = pos_z_q;
    lin_d   = lin_q;
    if (restart || (step_i && last)) begin
      pos_b_d = '0;
      pos_c_d = '0;
      pos_x_d = '0;
      pos_y_d = '0;
      pos_z_d = '0;
      lin_d   = '0;
    end else if (step_i) begin
      lin_d = lin_q + tsag_pkg::LINEAR_W'(1);
      if (!end_b) begin
        pos_b_d = pos_b_q + tsag_pkg::BYTE_W'(1);
      end else begin
        pos_b_d = '0;
        if (!end_c) begin
          pos_c_d = pos_c_q + IDX_W'(1);
        end else begin
          pos_c_d = '0;
          if (!end_x) begin
            pos_x_d = pos_x_q + IDX_W'(1);
          end else begin
            pos_x_d = '0;
            if (!end_y) begin
              pos_y_d = pos_y_q + IDX_W'(1);
            end else begin
              pos_y_d = '0;
              pos_z_d = pos_z_q + IDX_W'(1);
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_b_q <= '0;
      pos_c_q <= '0;
      pos_x_q <= '0;
      pos_y_q <= '0;
      pos_z_q <= '0;
      lin_q   <= '0;
    end else begin
      pos_b_q <= pos_b_d;
      pos_c_q <= pos_c_d;
      pos_x_q <= pos_x_d;
      pos_y_q <= pos_y_d;
      pos_z_q <= pos_z_d;
      lin_q   <= lin_d;
    end
  end

  assign pos_c_o          = pos_c_q;
  assign pos_x_o          = pos_x_q;
  assign pos_y_o          = pos_y_q;
  assign pos_z_o          = pos_z_q;
  assign info_o.linear    = lin_q;
  assign info_o.pos_byte  = pos_b_q;
  assign info_o.esl       = esl_q;
  assign info_o.dir       = dir_q;
  assign info_o.last      = last;

endmodule

`default_nettype wire

// ===== src/texture_swizzle_address_gen.sv =====
// Throughput: one transaction per cycle while the result side is not stalled; one byte
// address per accepted advance, from the registered read of the four offset tables
// feeding the adder stage.
// Reset: walk counters and linear counter clear, registers take their defaults;
// the offset tables are not cleared and need no clearing pass.
// texture_swizzle_address_gen: top level; depends on tsag_pkg, tsag_if, tsag_ram, tsag_walker
`timescale 1ns / 1ps
`default_nettype none

module texture_swizzle_address_gen #(
  parameter int unsigned TABLE_DEPTH = 4096
) (
  input wire logic  clk_i,
  input wire logic  rst_ni,
  tsag_cfg_if.sink  cfg_i,
  tsag_in_if.sink   in_i,
  tsag_out_if.source out_o
);

  localparam int unsigned OFFSET_BITS = tsag_pkg::OFFSET_BITS;
  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned SWZ_W = OFFSET_BITS + 3;

  logic                   in_acc, adv, load_ok, s1_move;
  logic                   we_c, we_x, we_y, we_z;
  logic [IDX_W-1:0]       waddr;
  logic [OFFSET_BITS-1:0] wdata;
  logic [IDX_W-1:0]       pos_c, pos_x, pos_y, pos_z;
  logic [OFFSET_BITS-1:0] off_c, off_x, off_y, off_z, off_sum;
  logic [SWZ_W-1:0]       swz;
  tsag_pkg::step_t        info, s1_info_q;
  logic                   s1_valid_q, out_valid_q;
  logic [tsag_pkg::LINEAR_W-1:0]   out_lin_q;
  logic [tsag_pkg::SWZ_ADDR_W-1:0] out_swz_q;
  logic                            out_dir_q, out_last_q;

  // handshakes
  assign cfg_i.ready = 1'b1;
  assign s1_move     = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !s1_valid_q || s1_move;
  assign in_acc      = in_i.valid && in_i.ready;

  // command decode
  assign load_ok = {20'd0, in_i.table_index} < 32'(TABLE_DEPTH);
  always_comb begin
    adv  = 1'b0;
    we_c = 1'b0;
    we_x = 1'b0;
    we_y = 1'b0;
    we_z = 1'b0;
    if (in_acc) begin
      unique case (in_i.cmd)
        tsag_pkg::CMD_LOAD_C:  we_c = load_ok;
        tsag_pkg::CMD_LOAD_X:  we_x = load_ok;
        tsag_pkg::CMD_LOAD_Y:  we_y = load_ok;
        tsag_pkg::CMD_LOAD_Z:  we_z = load_ok;
        tsag_pkg::CMD_ADVANCE: adv  = 1'b1;
        default: ;
      endcase
    end
  end

  assign waddr = IDX_W'(in_i.table_index);
  assign wdata = OFFSET_BITS'(in_i.table_value);

  // walk counters and configuration registers
  tsag_walker #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .IDX_W       (IDX_W)
  ) u_walker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_i.valid && cfg_i.ready),
    .cfg_idx_i  (cfg_i.reg_index),
    .cfg_data_i (cfg_i.wdata),
    .step_i     (adv),
    .pos_c_o    (pos_c),
    .pos_x_o    (pos_x),
    .pos_y_o    (pos_y),
    .pos_z_o    (pos_z),
    .info_o     (info)
  );

  // offset tables, read at the current walk position on an advance
  tsag_ram #(.WIDTH(OFFSET_BITS), .DEPTH(TABLE_DEPTH)) u_ram_c (
    .clk_i (clk_i), .we_i (we_c), .waddr_i (waddr), .wdata_i (wdata),
    .re_i (adv), .raddr_i (pos_c), .rdata_o (off_c)
  );
  tsag_ram #(.WIDTH(OFFSET_BITS), .DEPTH(TABLE_DEPTH)) u_ram_x (
    .clk_i (clk_i), .we_i (we_x), .waddr_i (waddr), .wdata_i (wdata),
    .re_i (adv), .raddr_i (pos_x), .rdata_o (off_x)
  );
  tsag_ram #(.WIDTH(OFFSET_BITS), .DEPTH(TABLE_DEPTH)) u_ram_y (
    .clk_i (clk_i), .we_i (we_y), .waddr_i (waddr), .wdata_i (wdata),
    .re_i (adv), .raddr_i (pos_y), .rdata_o (off_y)
  );
  tsag_ram #(.WIDTH(OFFSET_BITS), .DEPTH(TABLE_DEPTH)) u_ram_z (
    .clk_i (clk_i), .we_i (we_z), .waddr_i (waddr), .wdata_i (wdata),
    .re_i (adv), .raddr_i (pos_z), .rdata_o (off_z)
  );

  // stage 1: walk information alongside the table read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= 1'b1;
    end else if (s1_move) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_info_q <= info;
    end
  end

  // offset sum and swizzled byte address
  assign off_sum = off_z + off_y + off_x + off_c;
  assign swz     = (SWZ_W'(off_sum) << s1_info_q.esl) + SWZ_W'(s1_info_q.pos_byte);

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_move) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      out_lin_q  <= s1_info_q.linear;
      out_swz_q  <= tsag_pkg::SWZ_ADDR_W'(swz);
      out_dir_q  <= s1_info_q.dir;
      out_last_q <= s1_info_q.last;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.linear_address   = out_lin_q;
  assign out_o.swizzled_address = out_swz_q;
  assign out_o.source_is_linear = out_dir_q;
  assign out_o.last             = out_last_q;

`ifndef SYNTHESIS
  // an accepted advance always lands in stage 1
  a_adv_fills_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> s1_valid_q)
    else $error("advance transaction did not reach stage 1");

  // no input accepted while stage 1 is blocked by a stalled result
  a_no_accept_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && !out_o.ready) |-> !in_i.ready)
    else $error("input accepted while pipeline is stalled");

  // a result only appears after stage 1 held an item
  a_out_from_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_valid_q))
    else $error("result valid without a stage 1 item");

  // a register write inside the list restarts the walk
  a_cfg_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_i.valid && cfg_i.ready && cfg_i.reg_index <= tsag_pkg::REG_DIRECTION)
    |=> (info.linear == '0 && info.pos_byte == '0 && pos_c == '0 && pos_z == '0))
    else $error("walk not restarted after register write");
`endif

endmodule

`default_nettype wire

// ===== verif/texture_swizzle_address_gen_tb.sv =====
// texture_swizzle_address_gen_tb: self-checking testbench for the swizzle address generator
// drives table loads, advances and register writes, predicts every byte mapping in order
// depends on tsag_pkg, tsag_if and the texture_swizzle_address_gen rtl
`timescale 1ns / 1ps

module texture_swizzle_address_gen_tb;

  localparam int unsigned DEPTH      = 4096;
  localparam int unsigned NUM_TABLES = 4;
  localparam int unsigned PIPE_LAT   = 2;

  // register indexes past the end of the map, writes there change nothing
  localparam logic [tsag_pkg::REG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [tsag_pkg::REG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  // command codes the block drops
  localparam logic [tsag_pkg::CMD_W-1:0] CMD_SPARE_LO = 3'd5;
  localparam logic [tsag_pkg::CMD_W-1:0] CMD_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [tsag_pkg::LINEAR_W-1:0]   linear;
    logic [tsag_pkg::SWZ_ADDR_W-1:0] swizzled;
    logic                            src_linear;
    logic                            last;
  } byte_map_t;

  logic clk_i;
  logic rst_ni;

  tsag_cfg_if cfg_if ();
  tsag_in_if  in_if ();
  tsag_out_if out_if ();

  texture_swizzle_address_gen dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // predicted block state: tables indexed by load command, walk indexed the same way
  logic [tsag_pkg::TVAL_W-1:0]   offsets   [NUM_TABLES][DEPTH];
  bit                            loaded    [NUM_TABLES][DEPTH];
  logic [tsag_pkg::CNT_W-1:0]    dim_count [NUM_TABLES];
  logic [tsag_pkg::ESL_W-1:0]    elem_log2;
  logic                          dir_swizzle;
  logic [tsag_pkg::BYTE_W-1:0]   byte_pos;
  int unsigned                   dim_pos   [NUM_TABLES];
  logic [tsag_pkg::LINEAR_W-1:0] linear_pos;

  byte_map_t   pending_maps [$];
  int unsigned fail_count     = 0;
  int unsigned send_idle_pct  = 19;
  int unsigned sink_stall_pct = 78;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // hard stop
  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  // result side backpressure
  always @(posedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  function automatic int unsigned used_count(logic [tsag_pkg::CNT_W-1:0] raw);
    if (raw == '0) return 1;
    if (raw > DEPTH) return DEPTH;
    return 32'(raw);
  endfunction

  function automatic void restart_walk();
    byte_pos   = '0;
    linear_pos = '0;
    foreach (dim_pos[t]) dim_pos[t] = 0;
  endfunction

  // mapping for the current walk position, then step the walk
  function automatic byte_map_t next_byte_map();
    byte_map_t m;
    logic [tsag_pkg::TVAL_W-1:0] sum;
    bit at_end [NUM_TABLES];
    bit byte_end;
    bit carry;
    sum = offsets[tsag_pkg::CMD_LOAD_C][dim_pos[tsag_pkg::CMD_LOAD_C]]
        + offsets[tsag_pkg::CMD_LOAD_X][dim_pos[tsag_pkg::CMD_LOAD_X]]
        + offsets[tsag_pkg::CMD_LOAD_Y][dim_pos[tsag_pkg::CMD_LOAD_Y]]
        + offsets[tsag_pkg::CMD_LOAD_Z][dim_pos[tsag_pkg::CMD_LOAD_Z]];
    byte_end = (int'(byte_pos) + 1) >= (1 << elem_log2);
    foreach (at_end[t]) at_end[t] = (dim_pos[t] + 1) >= used_count(dim_count[t]);
    m.linear     = linear_pos;
    m.swizzled   = (tsag_pkg::SWZ_ADDR_W'(sum) << elem_log2)
                 + tsag_pkg::SWZ_ADDR_W'(byte_pos);
    m.src_linear = dir_swizzle;
    m.last       = byte_end && at_end[0] && at_end[1] && at_end[2] && at_end[3];
    if (m.last) begin
      restart_walk();
    end else begin
      linear_pos = linear_pos + tsag_pkg::LINEAR_W'(1);
      if (!byte_end) begin
        byte_pos = byte_pos + tsag_pkg::BYTE_W'(1);
      end else begin
        // byte fastest, then channel, x, y, z
        byte_pos = '0;
        carry    = 1'b1;
        for (int t = 0; t < NUM_TABLES; t++) begin
          if (carry) begin
            if (!at_end[t]) begin
              dim_pos[t]++;
              carry = 1'b0;
            end else begin
              dim_pos[t] = 0;
            end
          end
        end
      end
    end
    return m;
  endfunction

  // update the prediction for one accepted input transaction
  function automatic void apply_item(logic [tsag_pkg::CMD_W-1:0] code,
                                     logic [tsag_pkg::TIDX_W-1:0] idx,
                                     logic [tsag_pkg::TVAL_W-1:0] val);
    if (code <= tsag_pkg::CMD_LOAD_Z) begin
      offsets[code[1:0]][idx] = val;
      loaded[code[1:0]][idx]  = 1'b1;
    end else if (code == tsag_pkg::CMD_ADVANCE) begin
      pending_maps.push_back(next_byte_map());
    end
  endfunction

  function automatic void check_field(string name, logic [tsag_pkg::LINEAR_W-1:0] want,
                                      logic [tsag_pkg::LINEAR_W-1:0] got);
    if (got !== want) begin
      $display("%0t mismatch on %s: expected %0h, actual %0h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // result checker
  always @(posedge clk_i) begin
    byte_map_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_maps.size() == 0) begin
        $display("%0t unexpected result: expected none, actual linear %0h swizzled %0h",
                 $time, out_if.linear_address, out_if.swizzled_address);
        fail_count++;
      end else begin
        want = pending_maps.pop_front();
        check_field("linear_address", want.linear, out_if.linear_address);
        check_field("swizzled_address", tsag_pkg::LINEAR_W'(want.swizzled),
                    tsag_pkg::LINEAR_W'(out_if.swizzled_address));
        check_field("source_is_linear", tsag_pkg::LINEAR_W'(want.src_linear),
                    tsag_pkg::LINEAR_W'(out_if.source_is_linear));
        check_field("last", tsag_pkg::LINEAR_W'(want.last), tsag_pkg::LINEAR_W'(out_if.last));
      end
    end
  end

  // one input transaction, with random idle cycles ahead of it
  task automatic send_item(logic [tsag_pkg::CMD_W-1:0] code, logic [tsag_pkg::TIDX_W-1:0] idx,
                           logic [tsag_pkg::TVAL_W-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.cmd         <= code;
    in_if.table_index <= idx;
    in_if.table_value <= val;
    do @(posedge clk_i); while (!in_if.ready);
    apply_item(code, idx, val);
  endtask

  // wait until every predicted result has come back and the pipe is empty
  task automatic drain();
    in_if.valid <= 1'b0;
    while (pending_maps.size() != 0) @(posedge clk_i);
    repeat (PIPE_LAT + 2) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [tsag_pkg::REG_IDX_W-1:0] idx,
                           logic [tsag_pkg::CNT_W-1:0] data);
    drain();
    cfg_if.valid     <= 1'b1;
    cfg_if.reg_index <= idx;
    cfg_if.wdata     <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (idx)
      tsag_pkg::REG_CHANNEL_COUNT, tsag_pkg::REG_X_COUNT, tsag_pkg::REG_Y_COUNT,
      tsag_pkg::REG_Z_COUNT: begin
        dim_count[idx[1:0]] = data;
        restart_walk();
      end
      tsag_pkg::REG_ELEM_LOG2: begin
        elem_log2 = data[tsag_pkg::ESL_W-1:0];
        restart_walk();
      end
      tsag_pkg::REG_DIRECTION: begin
        dir_swizzle = data[0];
        restart_walk();
      end
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic write_counts(logic [tsag_pkg::CNT_W-1:0] nc, logic [tsag_pkg::CNT_W-1:0] nx,
                              logic [tsag_pkg::CNT_W-1:0] ny, logic [tsag_pkg::CNT_W-1:0] nz);
    write_reg(tsag_pkg::REG_CHANNEL_COUNT, nc);
    write_reg(tsag_pkg::REG_X_COUNT, nx);
    write_reg(tsag_pkg::REG_Y_COUNT, ny);
    write_reg(tsag_pkg::REG_Z_COUNT, nz);
  endtask

  // advances, each preceded by loads of any table entry the walk is about to read
  task automatic advance_bytes(int unsigned n);
    repeat (n) begin
      for (int t = tsag_pkg::CMD_LOAD_C; t <= tsag_pkg::CMD_LOAD_Z; t++) begin
        if (!loaded[t][dim_pos[t]])
          send_item(tsag_pkg::CMD_W'(t), tsag_pkg::TIDX_W'(dim_pos[t]), $urandom);
      end
      send_item(tsag_pkg::CMD_ADVANCE, tsag_pkg::TIDX_W'($urandom), $urandom);
    end
  endtask

  // reset defaults, all-ones offsets and the edges of the index range
  task automatic test_defaults_and_extremes();
    send_item(tsag_pkg::CMD_LOAD_C, '0, '1);
    send_item(tsag_pkg::CMD_LOAD_X, '0, '1);
    send_item(tsag_pkg::CMD_LOAD_Y, '0, '1);
    send_item(tsag_pkg::CMD_LOAD_Z, '0, '1);
    send_item(tsag_pkg::CMD_LOAD_Z, '1, '0);
    send_item(tsag_pkg::CMD_LOAD_C, '1, '1);
    advance_bytes(2);
  endtask

  // eight byte elements, unswizzle direction, walk past the end of the volume
  task automatic test_element_size_walk();
    write_counts(tsag_pkg::CNT_W'(1), tsag_pkg::CNT_W'(1), tsag_pkg::CNT_W'(1),
                 tsag_pkg::CNT_W'(1));
    write_reg(tsag_pkg::REG_ELEM_LOG2, 13'h1FFF);
    write_reg(tsag_pkg::REG_DIRECTION, 13'h1FFE);
    advance_bytes(9);
  endtask

  // zero count, full table depth and the largest count value
  task automatic test_count_limits();
    write_reg(tsag_pkg::REG_ELEM_LOG2, '0);
    write_counts('0, tsag_pkg::CNT_W'(DEPTH), '1, '0);
    advance_bytes(5);
  endtask

  // spare register writes and unused commands leave the walk alone, real writes restart it
  task automatic test_walk_restart();
    write_counts(tsag_pkg::CNT_W'(2), tsag_pkg::CNT_W'(2), tsag_pkg::CNT_W'(2),
                 tsag_pkg::CNT_W'(1));
    advance_bytes(3);
    write_reg(REG_SPARE_LO, tsag_pkg::CNT_W'($urandom));
    advance_bytes(2);
    write_reg(REG_SPARE_HI, tsag_pkg::CNT_W'($urandom));
    for (int c = CMD_SPARE_LO; c <= CMD_SPARE_HI; c++)
      send_item(tsag_pkg::CMD_W'(c), tsag_pkg::TIDX_W'($urandom), $urandom);
    write_reg(tsag_pkg::REG_DIRECTION, tsag_pkg::CNT_W'(1));
    advance_bytes(9);
  endtask

  // random configuration, mostly small volumes so the walk wraps often
  task automatic pick_config();
    int unsigned roll;
    logic [tsag_pkg::CNT_W-1:0] cnt;
    for (int t = tsag_pkg::REG_CHANNEL_COUNT; t <= tsag_pkg::REG_Z_COUNT; t++) begin
      roll = $urandom_range(99);
      if (roll < 6)       cnt = tsag_pkg::CNT_W'(DEPTH);
      else if (roll < 9)  cnt = '1;
      else if (roll < 12) cnt = '0;
      else if (roll < 16) cnt = tsag_pkg::CNT_W'($urandom);
      else                cnt = tsag_pkg::CNT_W'($urandom_range(3, 1));
      write_reg(tsag_pkg::REG_IDX_W'(t), cnt);
    end
    write_reg(tsag_pkg::REG_ELEM_LOG2, tsag_pkg::CNT_W'($urandom));
    write_reg(tsag_pkg::REG_DIRECTION, tsag_pkg::CNT_W'($urandom));
    if ($urandom_range(3) == 0)
      write_reg(tsag_pkg::REG_IDX_W'($urandom_range(REG_SPARE_HI, REG_SPARE_LO)),
                tsag_pkg::CNT_W'($urandom));
  endtask

  task automatic test_random_walks(int unsigned rounds, int unsigned items_per_round);
    int unsigned roll;
    int unsigned t;
    int unsigned hi;
    for (int unsigned r = 0; r < rounds; r++) begin
      if (r < rounds / 3) begin
        send_idle_pct  = 19;
        sink_stall_pct = 78;
      end else if (r < 2 * rounds / 3) begin
        send_idle_pct  = 78;
        sink_stall_pct = 19;
      end else begin
        send_idle_pct  = 0;
        sink_stall_pct = 0;
      end
      pick_config();
      repeat (items_per_round) begin
        roll = $urandom_range(99);
        t    = $urandom_range(tsag_pkg::CMD_LOAD_Z, tsag_pkg::CMD_LOAD_C);
        if (roll < 65) begin
          advance_bytes(1);
        end else if (roll < 85) begin
          // rewrite an entry the walk is using
          hi = used_count(dim_count[t]);
          if (hi > 8) hi = 8;
          send_item(tsag_pkg::CMD_W'(t), tsag_pkg::TIDX_W'($urandom_range(hi - 1, 0)),
                    ($urandom_range(9) == 0) ? '1 : $urandom);
        end else if (roll < 93) begin
          send_item(tsag_pkg::CMD_W'(t), tsag_pkg::TIDX_W'($urandom), $urandom);
        end else begin
          send_item(tsag_pkg::CMD_W'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO)),
                    tsag_pkg::TIDX_W'($urandom), $urandom);
        end
      end
    end
  endtask

  // main sequence
  initial begin
    rst_ni            = 1'b0;
    in_if.valid       = 1'b0;
    in_if.cmd         = '0;
    in_if.table_index = '0;
    in_if.table_value = '0;
    cfg_if.valid      = 1'b0;
    cfg_if.reg_index  = '0;
    cfg_if.wdata      = '0;
    foreach (dim_count[t]) dim_count[t] = tsag_pkg::CNT_W'(1);
    elem_log2   = '0;
    dir_swizzle = 1'b1;
    restart_walk();

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_defaults_and_extremes();
    test_element_size_walk();
    test_count_limits();
    test_walk_restart();
    test_random_walks(12, 45);

    drain();
    repeat (4 * PIPE_LAT) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/tsag_pkg.sv
src/tsag_if.sv
src/tsag_ram.sv
src/tsag_walker.sv
src/texture_swizzle_address_gen.sv
verif/texture_swizzle_address_gen_tb.sv
